/* rtl/core/sts_pkg.sv */
// Shared types and constants of the session slot table.
// No dependencies; sts_ctrl, sts_datapath and the top level import it.
`default_nettype none

package sts_pkg;

    localparam int SLOT_AW = 6;

    localparam logic [3:0] OP_OPEN     = 4'd0;
    localparam logic [3:0] OP_REGISTER = 4'd1;
    localparam logic [3:0] OP_NOTE     = 4'd2;
    localparam logic [3:0] OP_CHECK    = 4'd3;
    localparam logic [3:0] OP_CLOSE_H  = 4'd4;
    localparam logic [3:0] OP_CLOSE_ID = 4'd5;
    localparam logic [3:0] OP_UNREG    = 4'd6;
    localparam logic [3:0] OP_AGE      = 4'd7;
    localparam logic [3:0] OP_SHUTDOWN = 4'd8;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FREE    = 3'd1;
    localparam logic [2:0] ST_ALREADY    = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

    localparam logic [31:0] USECS_PER_SEC = 32'd1000000;
    localparam logic [31:0] LIMIT_RESET   = 32'd120000000;

    typedef struct packed {
        logic               load;
        logic               issue;
        logic [SLOT_AW-1:0] addr;
        logic               final_step;
        logic               finish;
        logic               age_end;
    } sts_cmd_t;

    typedef struct packed {
        logic [3:0]         op;
        logic               h_ok;
        logic [SLOT_AW-1:0] h_idx;
        logic [SLOT_AW-1:0] rr_next;
        logic               hit;
        logic               e_valid;
        logic               e_final;
        logic               stall;
        logic               out_free;
    } sts_stat_t;

    // Round-robin successor of a slot index, wrapping after top.
    function automatic logic [SLOT_AW-1:0] slot_after(input logic [SLOT_AW-1:0] i,
                                                      input logic [SLOT_AW-1:0] top);
        return (i == top) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/sts_ctrl.sv */
// Sequencer of the session slot table: dispatch, slot scan and result steps.
// Depends on sts_pkg; drives sts_datapath through command and status structs.
`default_nettype none

module sts_ctrl import sts_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sts_stat_t stat,
    output sts_cmd_t       cmd
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_START   = 5'b00010,
        S_SCAN    = 5'b00100,
        S_FINISH  = 5'b01000,
        S_AGE_END = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          stop;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        stop           = 1'b0;
        cmd            = '0;
        cmd.load       = in_valid && (state_reg == S_IDLE);
        cmd.addr       = SLOT_AW'(addr_reg);
        cmd.final_step = (rem_reg == CW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                rem_next = CW'(NUM_SLOTS);
                addr_next = '0;
                priority case (stat.op)
                    OP_OPEN:
                    begin
                        addr_next  = stat.rr_next[IW-1:0];
                        state_next = S_SCAN;
                    end
                    OP_REGISTER, OP_NOTE, OP_CLOSE_ID, OP_AGE:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_CHECK, OP_UNREG:
                    begin
                        addr_next  = stat.h_idx[IW-1:0];
                        rem_next   = CW'(1);
                        state_next = stat.h_ok ? S_SCAN : S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                // A hit ends a search at once; the age sweep runs to the end.
                stop = stat.hit || (stat.e_valid && stat.e_final && !stat.stall);
                cmd.issue = (rem_reg != '0) && !stat.stall && !stop;
                if (cmd.issue)
                begin
                    addr_next = IW'(slot_after(SLOT_AW'(addr_reg), SLOT_AW'(NUM_SLOTS - 1)));
                    rem_next  = rem_reg - 1'b1;
                end
                if (stop)
                begin
                    state_next = (stat.op == OP_AGE) ? S_AGE_END : S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_AGE_END:
            begin
                cmd.age_end = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sts_datapath.sv */
// Slot flags, id and timestamp memories, slot evaluation and the result register.
// Depends on sts_pkg and sts_ram; commanded by sts_ctrl.
`default_nettype none

module sts_datapath import sts_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sts_cmd_t    cmd,
    output sts_stat_t        stat,
    input  wire logic [3:0]  op,
    input  wire logic [15:0] conn_id,
    input  wire logic [31:0] handle_in,
    input  wire logic [31:0] now_usecs,
    input  wire logic        cfg_wr,
    input  wire logic [11:0] cfg_secs,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [6:0]       handle_out,
    output logic             found,
    output logic             teardown_conns,
    output logic             last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [3:0]           op_reg;
    logic [15:0]          conn_reg;
    logic [31:0]          handle_reg;
    logic [31:0]          now_reg;
    logic [31:0]          limit_reg;
    logic [NUM_SLOTS-1:0] live_reg, live_next;
    logic [NUM_SLOTS-1:0] regd_reg, regd_next;
    logic [IW-1:0]        rr_reg, rr_next;
    logic                 e_valid_reg, e_final_reg;
    logic [IW-1:0]        e_idx_reg;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic [6:0]           handle_reg7;
    logic                 found_reg, teardown_reg, last_reg;

    logic [15:0] conn_rdata;
    logic [31:0] time_rdata;
    logic        conn_we, time_we;
    logic [31:0] age;
    logic [31:0] hm1;
    logic [IW-1:0] h_idx;
    logic        h_ok, out_free, e_live, e_regd, conn_eq, aged, cand;
    logic        hit, age_close, age_rep, stall;
    logic        emit, emit_found, emit_td, emit_last;
    logic [2:0]  emit_status;
    logic [6:0]  emit_handle;

    sts_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_conn_ram (
        .clk   (clk),
        .we    (conn_we),
        .waddr (hit_idx_reg),
        .wdata (conn_reg),
        .re    (cmd.issue),
        .raddr (cmd.addr[IW-1:0]),
        .rdata (conn_rdata)
    );

    sts_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (hit_idx_reg),
        .wdata (now_reg),
        .re    (cmd.issue),
        .raddr (cmd.addr[IW-1:0]),
        .rdata (time_rdata)
    );

    assign hm1      = handle_reg - 32'd1;
    assign h_idx    = hm1[IW-1:0];
    assign h_ok     = (handle_reg != 32'd0) && (handle_reg <= 32'(NUM_SLOTS));
    assign out_free = !out_valid_reg || out_ready;

    assign e_live  = live_reg[e_idx_reg];
    assign e_regd  = regd_reg[e_idx_reg];
    assign conn_eq = (conn_rdata == conn_reg);
    // Wrapping age: the subtraction is taken modulo 2^32.
    assign age     = now_reg - time_rdata;
    assign aged    = (age >= limit_reg);

    always_comb
    begin
        priority case (op_reg)
            OP_OPEN:                          cand = !e_live;
            OP_REGISTER, OP_NOTE, OP_CLOSE_ID,
            OP_UNREG:                         cand = e_live && conn_eq;
            OP_CHECK:                         cand = e_live && conn_eq && e_regd;
            default:                          cand = 1'b0;
        endcase
    end

    assign hit       = e_valid_reg && cand;
    assign age_close = e_valid_reg && (op_reg == OP_AGE) && e_live && aged;
    assign age_rep   = age_close && e_regd;
    // A second report cannot be held while the first still waits for the output.
    assign stall     = age_rep && pend_valid_reg && !out_free;

    always_comb
    begin
        live_next       = live_reg;
        regd_next       = regd_reg;
        rr_next         = rr_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        conn_we         = 1'b0;
        time_we         = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_OK;
        emit_handle     = 7'd0;
        emit_found      = 1'b0;
        emit_td         = 1'b0;
        emit_last       = 1'b1;

        if (cmd.load)
        begin
            hit_next        = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (hit)
        begin
            hit_next     = 1'b1;
            hit_idx_next = e_idx_reg;
        end

        if (age_close && !stall)
        begin
            live_next[e_idx_reg] = 1'b0;
            regd_next[e_idx_reg] = 1'b0;
            if (age_rep)
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = e_idx_reg;
                if (pend_valid_reg)
                begin
                    emit        = 1'b1;
                    emit_handle = 7'(pend_idx_reg) + 7'd1;
                    emit_found  = 1'b1;
                    emit_td     = 1'b1;
                    emit_last   = 1'b0;
                end
            end
        end

        if (cmd.age_end && out_free)
        begin
            emit            = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                emit_handle = 7'(pend_idx_reg) + 7'd1;
                emit_found  = 1'b1;
                emit_td     = 1'b1;
            end
        end

        if (cmd.finish && out_free)
        begin
            emit = 1'b1;
            priority case (op_reg)
                OP_OPEN:
                begin
                    if (hit_reg)
                    begin
                        live_next[hit_idx_reg] = 1'b1;
                        regd_next[hit_idx_reg] = 1'b0;
                        conn_we     = 1'b1;
                        time_we     = 1'b1;
                        rr_next     = hit_idx_reg;
                        emit_handle = 7'(hit_idx_reg) + 7'd1;
                    end
                    else
                    begin
                        rr_next     = IW'(slot_after(SLOT_AW'(rr_reg), SLOT_AW'(NUM_SLOTS - 1)));
                        emit_status = ST_NO_FREE;
                    end
                end
                OP_REGISTER:
                begin
                    if (!hit_reg)
                    begin
                        emit_status = ST_NO_FREE;
                    end
                    else
                    begin
                        emit_handle = 7'(hit_idx_reg) + 7'd1;
                        emit_found  = 1'b1;
                        if (regd_reg[hit_idx_reg])
                        begin
                            emit_status = ST_ALREADY;
                        end
                        else
                        begin
                            regd_next[hit_idx_reg] = 1'b1;
                        end
                    end
                end
                OP_NOTE:
                begin
                    if (hit_reg)
                    begin
                        time_we     = 1'b1;
                        emit_handle = 7'(hit_idx_reg) + 7'd1;
                        emit_found  = 1'b1;
                    end
                    else
                    begin
                        emit_status = ST_NOT_FOUND;
                    end
                end
                OP_CHECK:
                begin
                    if (hit_reg)
                    begin
                        emit_handle = 7'(hit_idx_reg) + 7'd1;
                        emit_found  = 1'b1;
                    end
                    else
                    begin
                        emit_status = ST_BAD_HANDLE;
                    end
                end
                OP_CLOSE_H:
                begin
                    if (!h_ok)
                    begin
                        emit_status = ST_BAD_HANDLE;
                    end
                    else if (!live_reg[h_idx])
                    begin
                        emit_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        live_next[h_idx] = 1'b0;
                        regd_next[h_idx] = 1'b0;
                        emit_handle = 7'(h_idx) + 7'd1;
                        emit_found  = 1'b1;
                    end
                end
                OP_CLOSE_ID, OP_UNREG:
                begin
                    if (hit_reg)
                    begin
                        live_next[hit_idx_reg] = 1'b0;
                        regd_next[hit_idx_reg] = 1'b0;
                        emit_handle = 7'(hit_idx_reg) + 7'd1;
                        emit_found  = 1'b1;
                    end
                    else
                    begin
                        emit_status = (op_reg == OP_UNREG) ? ST_BAD_HANDLE : ST_NOT_FOUND;
                    end
                end
                OP_SHUTDOWN:
                begin
                    live_next = '0;
                    regd_next = '0;
                end
                default:
                begin
                    emit_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            regd_reg       <= '0;
            rr_reg         <= '0;
            e_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            live_reg       <= live_next;
            regd_reg       <= regd_next;
            rr_reg         <= rr_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            if (cmd.issue)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (!stall)
            begin
                e_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                limit_reg <= 32'(cfg_secs) * USECS_PER_SEC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        pend_idx_reg <= pend_idx_next;
        if (cmd.load)
        begin
            op_reg     <= op;
            conn_reg   <= conn_id;
            handle_reg <= handle_in;
            now_reg    <= now_usecs;
        end
        if (cmd.issue)
        begin
            e_idx_reg   <= cmd.addr[IW-1:0];
            e_final_reg <= cmd.final_step;
        end
        if (emit)
        begin
            status_reg   <= emit_status;
            handle_reg7  <= emit_handle;
            found_reg    <= emit_found;
            teardown_reg <= emit_td;
            last_reg     <= emit_last;
        end
    end

    always_comb
    begin
        stat          = '0;
        stat.op       = op_reg;
        stat.h_ok     = h_ok;
        stat.h_idx    = SLOT_AW'(h_idx);
        stat.rr_next  = slot_after(SLOT_AW'(rr_reg), SLOT_AW'(NUM_SLOTS - 1));
        stat.hit      = hit;
        stat.e_valid  = e_valid_reg;
        stat.e_final  = e_final_reg;
        stat.stall    = stall;
        stat.out_free = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign handle_out     = handle_reg7;
    assign found          = found_reg;
    assign teardown_conns = teardown_reg;
    assign last           = last_reg;

`ifndef NO_ASSERTIONS
    a_pend_only_aging: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (op_reg == OP_AGE))
        else $error("held age report outside an age tick");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result written over a word still waiting");
    a_stall_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !cmd.issue)
        else $error("slot read issued during an output stall");
    a_shutdown_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && out_free && (op_reg == OP_SHUTDOWN)) |=> (live_reg == '0))
        else $error("shutdown left a live slot");
`endif

endmodule

`default_nettype wire

/* rtl/core/session_table_with_inactivity_aging.sv */
// Top level of the session slot table with idle aging.
// Depends on sts_pkg, sts_ctrl, sts_datapath and sts_ram.
//
//  channel | handshake            | words
//  in      | in_valid / in_ready  | op, conn_id, handle_in, now_usecs
//  out     | out_valid / out_ready| status, handle_out, found, teardown_conns, last
//  cfg     | cfg_valid / cfg_ready| idle_timeout_secs
//
// One item is worked on at a time. Ops that walk the table (open, register, note,
// close by id, age tick) read one slot a cycle from the id and timestamp RAMs when
// not stalled, up to NUM_SLOTS slots; check and unregister read only the slot that
// a valid handle names. An age tick stalls its sweep while a report waits on out.
// Reset clears all slot flags and the pointer at once and sets a 120 s timeout.
`default_nettype none

module session_table_with_inactivity_aging import sts_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  op,
    input  wire logic [15:0] conn_id,
    input  wire logic [31:0] handle_in,
    input  wire logic [31:0] now_usecs,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [6:0]       handle_out,
    output logic             found,
    output logic             teardown_conns,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] idle_timeout_secs
);

    sts_cmd_t  cmd;
    sts_stat_t stat;

    assign cfg_ready = 1'b1;

    sts_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sts_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .conn_id        (conn_id),
        .handle_in      (handle_in),
        .now_usecs      (now_usecs),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_secs       (idle_timeout_secs),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .handle_out     (handle_out),
        .found          (found),
        .teardown_conns (teardown_conns),
        .last           (last)
    );

endmodule

`default_nettype wire
